/* rtl/gma_pkg.sv */
// Shared types, widths and arithmetic helpers for the Gram matrix accumulator.
package gma_pkg;

    localparam int IN_W   = 32;  // Q16.16 element
    localparam int ACC_W  = 64;  // Q32.32 sum
    localparam int IDX_W  = 4;   // row / column index
    localparam int COL_W  = 4;   // column count register
    localparam int CNT_W  = 6;   // lower-triangle entry count, up to 45

    localparam logic [COL_W-1:0] COLS_RESET = 4'd9;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // per-lane strobes from the row pipeline
    typedef struct packed {
        logic fire;     // row beat accepted, register products
        logic advance;  // products move into the accumulators
        logic clear;    // final row: accumulators restart from zero
    } lane_ctl_t;

    // handoff from the row pipeline to the emit stage
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] total;
    } emit_ctl_t;

    // signed add clamped to the 64-bit range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]))
            return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        return s;
    endfunction

    // n * (n + 1) / 2
    function automatic logic [CNT_W-1:0] tri_count(input logic [COL_W-1:0] n);
        logic [2*COL_W-1:0] p;
        p = {{COL_W{1'b0}}, n} * ({{COL_W{1'b0}}, n} + {{(2*COL_W-1){1'b0}}, 1'b1});
        return CNT_W'(p >> 1);
    endfunction

endpackage

/* rtl/gram_matrix_accumulator_core.sv */
// Top level of the Gram matrix (Z^T Z) accumulator with lane array and emitter.
// Row products are registered in the lanes, then enter the accumulators as the
//   stage advances; for a final row this loads the emitter and raises out_valid.
// Throughput: one row per cycle unless stalled; a final row emits n(n+1)/2 beats,
//   one per ready cycle, from a snapshot bank; a busy bank stalls a final row.
// Reset (rst_n, async, active low) zeroes all accumulators and sets cols to 9.
module gram_matrix_accumulator_core
    import gma_pkg::*;
#(
    parameter int MAX_COLS = 9
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [COL_W-1:0]        cfg_wdata,
    // row channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  elem0,
    input  logic signed [IN_W-1:0]  elem1,
    input  logic signed [IN_W-1:0]  elem2,
    input  logic signed [IN_W-1:0]  elem3,
    input  logic signed [IN_W-1:0]  elem4,
    input  logic signed [IN_W-1:0]  elem5,
    input  logic signed [IN_W-1:0]  elem6,
    input  logic signed [IN_W-1:0]  elem7,
    input  logic signed [IN_W-1:0]  elem8,
    input  logic                    final_row,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [IDX_W-1:0]        row_index,
    output logic [IDX_W-1:0]        col_index,
    output logic signed [ACC_W-1:0] sum_value,
    output logic                    last_entry
);

    localparam int TRI_SIZE = MAX_COLS * (MAX_COLS + 1) / 2;
    localparam logic [COL_W-1:0] COLS_LIMIT = COL_W'(MAX_COLS);

    logic [COL_W-1:0]        cols_reg;
    logic [COL_W-1:0]        ncols;
    logic signed [IN_W-1:0]  elem [9];

    // stage 1: products registered in the lanes
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_final_reg;
    logic [CNT_W-1:0]        s1_total_reg;
    logic                    s1_adv;
    logic                    in_fire;
    logic                    emit_free;

    lane_ctl_t               lane_ctl;
    emit_ctl_t               emit_ctl;
    logic signed [ACC_W-1:0] sums [TRI_SIZE];

    assign elem[0] = elem0;
    assign elem[1] = elem1;
    assign elem[2] = elem2;
    assign elem[3] = elem3;
    assign elem[4] = elem4;
    assign elem[5] = elem5;
    assign elem[6] = elem6;
    assign elem[7] = elem7;
    assign elem[8] = elem8;

    // column count register; 0 acts as 1, anything above the lane count is clipped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cols_reg <= COLS_RESET;
        else if (cfg_we)
            cols_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (cols_reg == '0)
            ncols = COL_W'(1);
        else if (cols_reg > COLS_LIMIT)
            ncols = COLS_LIMIT;
        else
            ncols = cols_reg;
    end

    // A final row can only retire into the accumulators once the snapshot
    // bank can take its sums; ordinary rows never wait.
    assign s1_adv   = s1_valid_reg && (!s1_final_reg || emit_free);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // the row's own column count decides how many entries its emission shows
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_final_reg <= final_row;
            s1_total_reg <= tri_count(ncols);
        end
    end

    assign lane_ctl.fire    = in_fire;
    assign lane_ctl.advance = s1_adv;
    assign lane_ctl.clear   = s1_final_reg;

    assign emit_ctl.load  = s1_adv && s1_final_reg;
    assign emit_ctl.total = s1_total_reg;

    // One lane per lower-triangle entry (i, j), j <= i, stored at
    // i*(i+1)/2 + j so the emit order is simply ascending lane number.
    for (genvar gi = 0; gi < MAX_COLS; gi++)
    begin : g_row
        for (genvar gj = 0; gj <= gi; gj++)
        begin : g_col
            localparam int K = gi * (gi + 1) / 2 + gj;
            logic active;
            assign active = (COL_W'(gi) < ncols);

            gma_mac_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (lane_ctl),
                .active (active),
                .a      (elem[gi]),
                .b      (elem[gj]),
                .sum    (sums[K])
            );
        end
    end

    gma_emit #(
        .TRI_SIZE (TRI_SIZE)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (emit_ctl),
        .sums       (sums),
        .free       (emit_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .col_index  (col_index),
        .sum_value  (sum_value),
        .last_entry (last_entry)
    );

    // a stalled final row holds the stage, so nothing new may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !in_ready)
        else $error("row accepted over a stalled stage");

    // only final rows ever stall the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> s1_final_reg)
        else $error("non-final row stalled");

    // a stalled row stays held in the stage until the bank can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stalled row lost");

endmodule

/* rtl/gma_mac_lane.sv */
// One multiply-accumulate lane: owns a single lower-triangle accumulator.
module gma_mac_lane
    import gma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctl_t               ctl,
    input  logic                    active,
    input  logic signed [IN_W-1:0]  a,
    input  logic signed [IN_W-1:0]  b,
    output logic signed [ACC_W-1:0] sum
);

    logic signed [ACC_W-1:0] prod_full;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // exact 32x32 signed product, operands sign-extended to 64 bits
    assign prod_full = a * b;
    // unused columns contribute zero
    assign prod_next = active ? prod_full : '0;

    assign sum      = sat_add(acc_reg, prod_reg);
    assign acc_next = ctl.clear ? '0 : sum;

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
            prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctl.advance)
            acc_reg <= acc_next;
    end

endmodule

/* rtl/gma_emit.sv */
// Merge stage: snapshots all lane sums, streams them one beat per ready cycle.
module gma_emit
    import gma_pkg::*;
#(
    parameter int TRI_SIZE = 45
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  emit_ctl_t               ctl,
    input  logic signed [ACC_W-1:0] sums [TRI_SIZE],
    output logic                    free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [IDX_W-1:0]        row_index,
    output logic [IDX_W-1:0]        col_index,
    output logic signed [ACC_W-1:0] sum_value,
    output logic                    last_entry
);

    logic signed [ACC_W-1:0] shadow_reg [TRI_SIZE];
    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        row_reg;
    logic [IDX_W-1:0]        col_reg;
    logic                    pop;
    logic                    last;

    assign last = (cnt_reg == CNT_W'(1));
    assign pop  = busy_reg && out_ready;
    // the bank frees up in the same cycle its last beat leaves
    assign free = !busy_reg || (last && out_ready);

    // shift chain: head is always the next entry in triangle order
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int k = 0; k < TRI_SIZE; k++)
                shadow_reg[k] <= sums[k];
        end
        else if (pop)
        begin
            for (int k = 0; k < TRI_SIZE - 1; k++)
                shadow_reg[k] <= shadow_reg[k+1];
            shadow_reg[TRI_SIZE-1] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (ctl.load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ctl.total;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= !last;
            cnt_reg  <= cnt_reg - CNT_W'(1);
            if (col_reg == row_reg)
            begin
                row_reg <= row_reg + IDX_W'(1);
                col_reg <= '0;
            end
            else
            begin
                col_reg <= col_reg + IDX_W'(1);
            end
        end
    end

    assign out_valid  = busy_reg;
    assign row_index  = row_reg;
    assign col_index  = col_reg;
    assign sum_value  = shadow_reg[0];
    assign last_entry = last;

    // snapshot never overwrites entries still waiting to go out
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (!busy_reg || (last && out_ready)))
        else $error("emit bank loaded while busy");

    // lower triangle: column never passes row
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (col_reg <= row_reg))
        else $error("column above diagonal");

    // the closing entry of a matrix sits on the diagonal
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last) |-> (col_reg == row_reg))
        else $error("last entry off diagonal");

    // a busy bank always has entries left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("busy with empty count");

endmodule
